/* hdl/multi_axis_pdo_command_feedback_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the PDO command and feedback engine
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef MULTI_AXIS_PDO_COMMAND_FEEDBACK_DEFINES_SVH
`define MULTI_AXIS_PDO_COMMAND_FEEDBACK_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |-> (cons)) else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |=> (cons)) else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clock, resetn, ante, cons)
`define ASSERT_NEXT(label, clock, resetn, ante, cons)

`endif

`endif

/* hdl/mapdo_pkg.sv */
// ---------------------------------------------------------------------------
// mapdo_pkg
// Frame identifiers, controlwords, register map and the sequencer microcode.
// ---------------------------------------------------------------------------
package mapdo_pkg;

    // CAN identifiers
    localparam logic [10:0] ID_RX_POS = 11'h181;
    localparam logic [10:0] ID_RX_EFF = 11'h281;
    localparam logic [10:0] ID_TX_CMD = 11'h201;
    localparam logic [10:0] ID_SYNC   = 11'h080;

    // controlwords
    localparam logic [7:0] CW_SHUTDOWN = 8'h06;
    localparam logic [7:0] CW_ENABLE   = 8'h0f;
    localparam logic [7:0] CW_MOVE     = 8'h1f;

    localparam logic [3:0] LEN_FULL = 4'd8;
    localparam logic [3:0] LEN_NONE = 4'd0;

    // command codes
    localparam logic [1:0] CMD_FEEDBACK = 2'd0;
    localparam logic [1:0] CMD_TARGET   = 2'd1;
    localparam logic [1:0] CMD_SYNC     = 2'd2;
    localparam logic [1:0] CMD_DISABLE  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_POSVEL = 2'd1;
    localparam logic [1:0] KIND_EFFORT = 2'd2;

    // register map: paddr[2] selects the register index
    localparam int          APB_AW            = 3;
    localparam logic        REG_MOVE_DEADBAND = 1'b0;
    localparam logic [15:0] DEADBAND_RESET    = 16'd50;

    typedef logic [4:0] step_t;

    // program addresses
    localparam step_t S_FETCH      = 5'd0;
    localparam step_t S_FB_POS     = 5'd1;
    localparam step_t S_FB_POS_OUT = 5'd2;
    localparam step_t S_FB_EFF     = 5'd3;
    localparam step_t S_FB_EFF_OUT = 5'd4;
    localparam step_t S_TG_LOAD    = 5'd5;
    localparam step_t S_TG_READ    = 5'd6;
    localparam step_t S_TG_DIFF    = 5'd7;
    localparam step_t S_TG_CMP     = 5'd8;
    localparam step_t S_TG_ENCHK   = 5'd9;
    localparam step_t S_TG_SHUT    = 5'd10;
    localparam step_t S_TG_ENABLE  = 5'd11;
    localparam step_t S_TG_MOVE    = 5'd12;
    localparam step_t S_SYNC       = 5'd13;
    localparam step_t S_DA_START   = 5'd14;
    localparam step_t S_DA_CHECK   = 5'd15;
    localparam step_t S_DA_SHUT    = 5'd16;
    localparam step_t S_DA_NEXT    = 5'd17;
    localparam step_t S_DA_DONE    = 5'd18;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_IF_TRUE,
        JMP_IF_FALSE,
        JMP_DISPATCH
    } jmp_t;

    typedef enum logic [2:0] {
        C_POS_ID,
        C_EFF_ID,
        C_AXIS_OK,
        C_BIG,
        C_ENABLED,
        C_AX_LAST
    } cond_t;

    typedef enum logic [2:0] {
        E_NONE,
        E_REPORT_POS,
        E_REPORT_EFF,
        E_SHUTDOWN,
        E_ENABLE,
        E_MOVE,
        E_SYNC
    } emit_t;

    typedef enum logic [1:0] {
        L_NO,
        L_YES,
        L_NONE_HIGHER
    } last_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_LOAD_AX_POS,
        A_LOAD_AX_EFF,
        A_LOAD_AX_TGT,
        A_DIFF,
        A_WRITE_POS,
        A_SET_EN,
        A_CLR_EN,
        A_CLEAR_AX,
        A_INC_AX
    } act_t;

    typedef struct packed {
        jmp_t  jmp;
        cond_t cond;
        step_t target;
        emit_t emit;
        last_t last;
        act_t  act;
    } uword_t;

    function automatic uword_t uw(jmp_t j, cond_t c, step_t t, emit_t e, last_t l, act_t a);
        uword_t w;
        w.jmp    = j;
        w.cond   = c;
        w.target = t;
        w.emit   = e;
        w.last   = l;
        w.act    = a;
        return w;
    endfunction

    // control store
    function automatic uword_t ucode(step_t addr);
        uword_t w;
        unique case (addr)
            S_FETCH:      w = uw(JMP_DISPATCH, C_POS_ID, S_FETCH, E_NONE, L_NO, A_ACCEPT);
            S_FB_POS:     w = uw(JMP_IF_FALSE, C_POS_ID, S_FB_EFF, E_NONE, L_NO,
                                 A_LOAD_AX_POS);
            S_FB_POS_OUT: w = uw(JMP_ALWAYS, C_POS_ID, S_FETCH, E_REPORT_POS, L_YES,
                                 A_WRITE_POS);
            S_FB_EFF:     w = uw(JMP_IF_FALSE, C_EFF_ID, S_FETCH, E_NONE, L_NO,
                                 A_LOAD_AX_EFF);
            S_FB_EFF_OUT: w = uw(JMP_ALWAYS, C_POS_ID, S_FETCH, E_REPORT_EFF, L_YES, A_NONE);
            S_TG_LOAD:    w = uw(JMP_IF_FALSE, C_AXIS_OK, S_FETCH, E_NONE, L_NO,
                                 A_LOAD_AX_TGT);
            S_TG_READ:    w = uw(JMP_NEXT, C_POS_ID, S_FETCH, E_NONE, L_NO, A_NONE);
            S_TG_DIFF:    w = uw(JMP_NEXT, C_POS_ID, S_FETCH, E_NONE, L_NO, A_DIFF);
            S_TG_CMP:     w = uw(JMP_IF_FALSE, C_BIG, S_FETCH, E_NONE, L_NO, A_NONE);
            S_TG_ENCHK:   w = uw(JMP_IF_TRUE, C_ENABLED, S_TG_MOVE, E_NONE, L_NO, A_NONE);
            S_TG_SHUT:    w = uw(JMP_NEXT, C_POS_ID, S_FETCH, E_SHUTDOWN, L_NO, A_NONE);
            S_TG_ENABLE:  w = uw(JMP_NEXT, C_POS_ID, S_FETCH, E_ENABLE, L_NO, A_SET_EN);
            S_TG_MOVE:    w = uw(JMP_ALWAYS, C_POS_ID, S_FETCH, E_MOVE, L_YES, A_NONE);
            S_SYNC:       w = uw(JMP_ALWAYS, C_POS_ID, S_FETCH, E_SYNC, L_YES, A_NONE);
            S_DA_START:   w = uw(JMP_NEXT, C_POS_ID, S_FETCH, E_NONE, L_NO, A_CLEAR_AX);
            S_DA_CHECK:   w = uw(JMP_IF_FALSE, C_ENABLED, S_DA_NEXT, E_NONE, L_NO, A_NONE);
            S_DA_SHUT:    w = uw(JMP_NEXT, C_POS_ID, S_FETCH, E_SHUTDOWN, L_NONE_HIGHER,
                                 A_CLR_EN);
            S_DA_NEXT:    w = uw(JMP_IF_FALSE, C_AX_LAST, S_DA_CHECK, E_NONE, L_NO,
                                 A_INC_AX);
            S_DA_DONE:    w = uw(JMP_ALWAYS, C_POS_ID, S_FETCH, E_NONE, L_NO, A_NONE);
            default:      w = uw(JMP_ALWAYS, C_POS_ID, S_FETCH, E_NONE, L_NO, A_NONE);
        endcase
        return w;
    endfunction

    // entry point of each command's routine
    function automatic step_t dispatch(logic [1:0] cmd);
        step_t s;
        unique case (cmd)
            CMD_FEEDBACK: s = S_FB_POS;
            CMD_TARGET:   s = S_TG_LOAD;
            CMD_SYNC:     s = S_SYNC;
            CMD_DISABLE:  s = S_DA_START;
            default:      s = S_FETCH;
        endcase
        return s;
    endfunction

endpackage

/* hdl/mapdo_if.sv */
// ---------------------------------------------------------------------------
// mapdo channel interfaces
// Valid/ready channels for input commands and for result items.
// ---------------------------------------------------------------------------
interface mapdo_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [10:0]        frame_id;
    logic [63:0]        frame_payload;
    logic [2:0]         axis;
    logic signed [31:0] target_pulses;

    modport source (
        output valid, command, frame_id, frame_payload, axis, target_pulses,
        input  ready
    );
    modport sink (
        input  valid, command, frame_id, frame_payload, axis, target_pulses,
        output ready
    );
endinterface

interface mapdo_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic [10:0]        tx_id;
    logic [3:0]         tx_length;
    logic [63:0]        tx_payload;
    logic               last;
    logic [2:0]         report_axis;
    logic signed [31:0] report_position;
    logic signed [31:0] report_velocity;
    logic signed [15:0] report_effort;

    modport source (
        output valid, result_kind, tx_id, tx_length, tx_payload, last, report_axis,
               report_position, report_velocity, report_effort,
        input  ready
    );
    modport sink (
        input  valid, result_kind, tx_id, tx_length, tx_payload, last, report_axis,
               report_position, report_velocity, report_effort,
        output ready
    );
endinterface

/* hdl/multi_axis_pdo_command_feedback.sv */
// ---------------------------------------------------------------------------
// multi_axis_pdo_command_feedback
// Microcoded PDO engine: feedback decode, joint targets, sync, disable-all.
// ---------------------------------------------------------------------------
// One microinstruction per cycle, except that fetch waits for an input item and
// an emit step holds while the output register is full and not being taken; a
// result is registered into the output register by its emit step. Target items
// end on a bad axis or inside the deadband, and send shutdown and enable before
// the move only for a disabled axis. Each routine's step count sets the rate.
// Reset (async, rst_n low): step counter to fetch, all enable marks and position
// valid bits cleared (positions read as zero), deadband to 50. No clearing pass.
`include "multi_axis_pdo_command_feedback_defines.svh"

module multi_axis_pdo_command_feedback
    import mapdo_pkg::*;
#(
    parameter int NUM_AXES = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    mapdo_req_if.sink         req,
    mapdo_rsp_if.source       rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    // sequencer
    step_t  upc_reg, upc_next;
    uword_t uword;
    logic   cond;
    logic   step_fire;
    logic   emit_fire;
    logic   out_free;

    // configuration
    logic [15:0] db_reg, db_next;
    logic        cfg_write;

    // latched item
    logic [10:0]        fid_reg;
    logic [63:0]        pay_reg;
    logic [2:0]         axis_reg;
    logic signed [31:0] tgt_reg;

    // datapath
    logic [AXW-1:0]     ax_reg, ax_next;
    logic [NUM_AXES-1:0] en_reg, en_next;
    logic [NUM_AXES-1:0] pos_vld_reg, pos_vld_next;
    logic [NUM_AXES-1:0] higher;
    logic [31:0]        pos_mem [NUM_AXES];
    logic [31:0]        rd_reg;
    logic               rd_vld_reg;
    logic [31:0]        pos_cur;
    logic signed [32:0] diff_reg;
    logic signed [32:0] db_ext;
    logic               any_higher;
    logic [10:0]        fid_pos_off;
    logic [10:0]        fid_eff_off;
    logic [10:0]        tx_cmd_id;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [10:0]        id_reg, id_next;
    logic [3:0]         len_reg, len_next;
    logic [63:0]        txpay_reg, txpay_next;
    logic               last_reg, last_next;
    logic [2:0]         rax_reg, rax_next;
    logic [31:0]        rpos_reg, rpos_next;
    logic [31:0]        rvel_reg, rvel_next;
    logic [15:0]        reff_reg, reff_next;

    // -----------------------------------------------------------------------
    // configuration port
    // -----------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MOVE_DEADBAND);
    assign db_next   = cfg_write ? pwdata[15:0] : db_reg;
    assign prdata    = (paddr[2] == REG_MOVE_DEADBAND) ? {16'b0, db_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            db_reg <= DEADBAND_RESET;
        end
        else
        begin
            db_reg <= db_next;
        end
    end

    // -----------------------------------------------------------------------
    // conditions
    // -----------------------------------------------------------------------
    assign uword       = ucode(upc_reg);
    assign fid_pos_off = fid_reg - ID_RX_POS;
    assign fid_eff_off = fid_reg - ID_RX_EFF;
    assign db_ext      = $signed({17'b0, db_reg});
    assign tx_cmd_id   = ID_TX_CMD + 11'(ax_reg);
    assign pos_cur     = rd_vld_reg ? rd_reg : 32'b0;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            higher[i] = en_reg[i] && (AXW'(i) > ax_reg);
        end
    end
    assign any_higher = |higher;

    always_comb
    begin
        unique case (uword.cond)
            C_POS_ID:  cond = (fid_reg >= ID_RX_POS) && (fid_pos_off < 11'(NUM_AXES));
            C_EFF_ID:  cond = (fid_reg >= ID_RX_EFF) && (fid_eff_off < 11'(NUM_AXES));
            C_AXIS_OK: cond = 8'(axis_reg) < 8'(NUM_AXES);
            C_BIG:     cond = (diff_reg > db_ext) || (diff_reg < -db_ext);
            C_ENABLED: cond = en_reg[ax_reg];
            C_AX_LAST: cond = ax_reg == AXW'(NUM_AXES - 1);
            default:   cond = 1'b0;
        endcase
    end

    // -----------------------------------------------------------------------
    // step counter
    // -----------------------------------------------------------------------
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (uword.act == A_ACCEPT);

    always_comb
    begin
        if (uword.act == A_ACCEPT)
        begin
            step_fire = req.valid;
        end
        else if (uword.emit != E_NONE)
        begin
            step_fire = out_free;
        end
        else
        begin
            step_fire = 1'b1;
        end
    end
    assign emit_fire = step_fire && (uword.emit != E_NONE);

    always_comb
    begin
        upc_next = upc_reg;
        if (step_fire)
        begin
            unique case (uword.jmp)
                JMP_NEXT:     upc_next = upc_reg + 5'd1;
                JMP_ALWAYS:   upc_next = uword.target;
                JMP_IF_TRUE:  upc_next = cond ? uword.target : upc_reg + 5'd1;
                JMP_IF_FALSE: upc_next = cond ? upc_reg + 5'd1 : uword.target;
                JMP_DISPATCH: upc_next = dispatch(req.command);
                default:      upc_next = S_FETCH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_FETCH;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    // -----------------------------------------------------------------------
    // item latch and datapath registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (step_fire && (uword.act == A_ACCEPT))
        begin
            fid_reg  <= req.frame_id;
            pay_reg  <= req.frame_payload;
            axis_reg <= req.axis;
            tgt_reg  <= req.target_pulses;
        end
        if (step_fire && (uword.act == A_DIFF))
        begin
            diff_reg <= $signed({tgt_reg[31], tgt_reg}) - $signed({pos_cur[31], pos_cur});
        end
    end

    always_comb
    begin
        ax_next      = ax_reg;
        en_next      = en_reg;
        pos_vld_next = pos_vld_reg;
        if (step_fire)
        begin
            case (uword.act)
                A_LOAD_AX_POS: ax_next = AXW'(fid_pos_off);
                A_LOAD_AX_EFF: ax_next = AXW'(fid_eff_off);
                A_LOAD_AX_TGT: ax_next = AXW'(axis_reg);
                A_CLEAR_AX:    ax_next = '0;
                A_INC_AX:      ax_next = cond ? ax_reg : ax_reg + 1'b1;
                A_SET_EN:      en_next[ax_reg] = 1'b1;
                A_CLR_EN:      en_next[ax_reg] = 1'b0;
                A_WRITE_POS:   pos_vld_next[ax_reg] = 1'b1;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg      <= '0;
            en_reg      <= '0;
            pos_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            ax_reg      <= ax_next;
            en_reg      <= en_next;
            pos_vld_reg <= pos_vld_next;
            rd_vld_reg  <= pos_vld_reg[ax_reg];
        end
    end

    // position store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (step_fire && (uword.act == A_WRITE_POS))
        begin
            pos_mem[ax_reg] <= pay_reg[31:0];
        end
        rd_reg <= pos_mem[ax_reg];
    end

    // -----------------------------------------------------------------------
    // result formatting
    // -----------------------------------------------------------------------
    always_comb
    begin
        kind_next  = KIND_TX;
        id_next    = 11'b0;
        len_next   = LEN_NONE;
        txpay_next = 64'b0;
        rax_next   = 3'b0;
        rpos_next  = 32'b0;
        rvel_next  = 32'b0;
        reff_next  = 16'b0;
        case (uword.emit)
            E_REPORT_POS:
            begin
                kind_next = KIND_POSVEL;
                rax_next  = 3'(ax_reg);
                rpos_next = pay_reg[31:0];
                rvel_next = pay_reg[63:32];
            end
            E_REPORT_EFF:
            begin
                kind_next = KIND_EFFORT;
                rax_next  = 3'(ax_reg);
                reff_next = pay_reg[15:0];
            end
            E_SHUTDOWN:
            begin
                id_next    = tx_cmd_id;
                len_next   = LEN_FULL;
                txpay_next = {24'b0, CW_SHUTDOWN, 32'b0};
            end
            E_ENABLE:
            begin
                id_next    = tx_cmd_id;
                len_next   = LEN_FULL;
                txpay_next = {24'b0, CW_ENABLE, 32'b0};
            end
            E_MOVE:
            begin
                id_next    = tx_cmd_id;
                len_next   = LEN_FULL;
                txpay_next = {24'b0, CW_MOVE, tgt_reg};
            end
            E_SYNC:
            begin
                id_next = ID_SYNC;
            end
            default: ;
        endcase

        case (uword.last)
            L_YES:         last_next = 1'b1;
            L_NONE_HIGHER: last_next = !any_higher;
            default:       last_next = 1'b0;
        endcase
    end

    assign out_valid_next = emit_fire ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            kind_reg  <= kind_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            txpay_reg <= txpay_next;
            last_reg  <= last_next;
            rax_reg   <= rax_next;
            rpos_reg  <= rpos_next;
            rvel_reg  <= rvel_next;
            reff_reg  <= reff_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.result_kind     = kind_reg;
    assign rsp.tx_id           = id_reg;
    assign rsp.tx_length       = len_reg;
    assign rsp.tx_payload      = txpay_reg;
    assign rsp.last            = last_reg;
    assign rsp.report_axis     = rax_reg;
    assign rsp.report_position = rpos_reg;
    assign rsp.report_velocity = rvel_reg;
    assign rsp.report_effort   = reff_reg;

    // -----------------------------------------------------------------------
    // checks
    // -----------------------------------------------------------------------
    // every routine takes at least one step after fetch
    `ASSERT_NEXT(a_no_back_to_back_accept, clk, rst_n, req.valid && req.ready, !req.ready)
    // a move frame only leaves for an axis already marked enabled
    `ASSERT_IMPLIES(a_move_needs_enable, clk, rst_n, emit_fire && (uword.emit == E_MOVE),
                    en_reg[ax_reg])
    // disable-all only addresses enabled axes
    `ASSERT_IMPLIES(a_disable_only_enabled, clk, rst_n,
                    emit_fire && (uword.act == A_CLR_EN), en_reg[ax_reg])

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the multi-axis PDO command and feedback engine
// The testbench drives feedback frames, joint targets, sync and disable-all
// commands over valid/ready channels. Idle cycles and output stalls are random
// outside one quiet phase. It programs the move deadband over APB between
// phases. An in-bench predictor of axis enable marks and stored positions, or
// the directed row, gives the expected result items, checked field by field.
// ----------------------------------------------------------------------------
module tb_top
    import mapdo_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int AXES = 7;
    localparam int DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 60;
    localparam logic [APB_AW-1:0] DEADBAND_ADDR = {REG_MOVE_DEADBAND, 2'b00};

    // how a directed row is checked
    localparam int EXP_PREDICTED = -1;
    localparam int EXP_NONE      = 0;
    localparam int EXP_ONE       = 1;

    typedef struct {
        logic [1:0]         command;
        logic [10:0]        frame_id;
        logic [63:0]        frame_payload;
        logic [2:0]         axis;
        logic signed [31:0] target_pulses;
    } pdo_cmd_t;

    typedef struct {
        logic [1:0]         kind;
        logic [10:0]        tx_id;
        logic [3:0]         tx_length;
        logic [63:0]        tx_payload;
        logic               last;
        logic [2:0]         axis;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [15:0] effort;
    } pdo_result_t;

    typedef struct {
        pdo_cmd_t    cmd;
        int          n_exp;
        pdo_result_t exp_r;
    } cmd_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    mapdo_req_if req_ch ();
    mapdo_rsp_if rsp_ch ();

    multi_axis_pdo_command_feedback #(
        .NUM_AXES (AXES)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predicted engine state
    logic               axis_on [AXES];
    logic signed [31:0] axis_pos [AXES];
    logic [15:0]        deadband;

    pdo_result_t pending_results [$];
    cmd_row_t    directed_rows [$];
    int          mismatches;
    int unsigned cycle_count;
    bit          quiet;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("tb_top: mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    function automatic pdo_result_t tx_frame(input logic [10:0] id, input logic [3:0] len,
                                             input logic [31:0] pos, input logic [7:0] cw);
        pdo_result_t r = '{default: '0};
        r.kind       = KIND_TX;
        r.tx_id      = id;
        r.tx_length  = len;
        r.tx_payload = {24'd0, cw, pos};
        return r;
    endfunction

    function automatic pdo_result_t posvel_report(input logic [2:0] a,
                                                  input logic [31:0] pos,
                                                  input logic [31:0] vel);
        pdo_result_t r = '{default: '0};
        r.kind     = KIND_POSVEL;
        r.axis     = a;
        r.position = pos;
        r.velocity = vel;
        return r;
    endfunction

    function automatic pdo_result_t effort_report(input logic [2:0] a, input logic [15:0] eff);
        pdo_result_t r = '{default: '0};
        r.kind   = KIND_EFFORT;
        r.axis   = a;
        r.effort = eff;
        return r;
    endfunction

    // advance the predicted state by one command; queue its results if asked
    function automatic void predict_pdo(input pdo_cmd_t c, input bit keep);
        pdo_result_t batch [$];
        int          a;
        longint      diff;
        logic [10:0] id;
        case (c.command)
            CMD_FEEDBACK:
            begin
                if (c.frame_id >= ID_RX_POS && c.frame_id < ID_RX_POS + AXES)
                begin
                    a = c.frame_id - ID_RX_POS;
                    axis_pos[a] = c.frame_payload[31:0];
                    batch.push_back(posvel_report(3'(a), c.frame_payload[31:0],
                                                  c.frame_payload[63:32]));
                end
                else if (c.frame_id >= ID_RX_EFF && c.frame_id < ID_RX_EFF + AXES)
                begin
                    a = c.frame_id - ID_RX_EFF;
                    batch.push_back(effort_report(3'(a), c.frame_payload[15:0]));
                end
            end
            CMD_TARGET:
            begin
                if (c.axis < AXES)
                begin
                    diff = longint'(c.target_pulses) - longint'(axis_pos[c.axis]);
                    if (diff < 0)
                        diff = -diff;
                    if (diff > longint'(deadband))
                    begin
                        id = ID_TX_CMD + 11'(c.axis);
                        if (!axis_on[c.axis])
                        begin
                            batch.push_back(tx_frame(id, LEN_FULL, '0, CW_SHUTDOWN));
                            batch.push_back(tx_frame(id, LEN_FULL, '0, CW_ENABLE));
                            axis_on[c.axis] = 1'b1;
                        end
                        batch.push_back(tx_frame(id, LEN_FULL, c.target_pulses, CW_MOVE));
                    end
                end
            end
            CMD_SYNC:
                batch.push_back(tx_frame(ID_SYNC, LEN_NONE, '0, '0));
            default:
            begin
                for (a = 0; a < AXES; a++)
                begin
                    if (axis_on[a])
                    begin
                        batch.push_back(tx_frame(ID_TX_CMD + 11'(a), LEN_FULL, '0,
                                                 CW_SHUTDOWN));
                        axis_on[a] = 1'b0;
                    end
                end
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        if (keep)
            foreach (batch[i])
                pending_results.push_back(batch[i]);
    endfunction

    function automatic void add_row(input logic [1:0] cmd, input logic [10:0] fid,
                                    input logic [63:0] pay, input logic [2:0] ax,
                                    input logic [31:0] tgt, input int n_exp,
                                    input pdo_result_t exp_r);
        cmd_row_t row;
        row.cmd.command       = cmd;
        row.cmd.frame_id      = fid;
        row.cmd.frame_payload = pay;
        row.cmd.axis          = ax;
        row.cmd.target_pulses = tgt;
        row.n_exp             = n_exp;
        row.exp_r             = exp_r;
        directed_rows.push_back(row);
    endfunction

    function automatic pdo_cmd_t random_cmd();
        pdo_cmd_t c;
        int       pick;
        longint   offset;
        c.command       = 2'($urandom);
        c.frame_id      = 11'($urandom);
        c.frame_payload = {$urandom, $urandom};
        c.axis          = 3'($urandom);
        c.target_pulses = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            c.command  = CMD_FEEDBACK;
            c.frame_id = ID_RX_POS + 11'($urandom_range(0, AXES - 1));
        end
        else if (pick < 32)
        begin
            c.command  = CMD_FEEDBACK;
            c.frame_id = ID_RX_EFF + 11'($urandom_range(0, AXES - 1));
        end
        else if (pick < 37)
            c.command = CMD_FEEDBACK;
        else if (pick < 79)
        begin
            c.command = CMD_TARGET;
            if (pick < 77)
                c.axis = 3'($urandom_range(0, AXES - 1));
            // land near the stored position to hit both sides of the deadband
            if (c.axis < AXES && $urandom_range(0, 1))
            begin
                offset = longint'($urandom_range(0, 2 * deadband + 8)) - deadband - 4;
                c.target_pulses = 32'(longint'(axis_pos[c.axis]) + offset);
            end
        end
        else if (pick < 89)
            c.command = CMD_SYNC;
        else
            c.command = CMD_DISABLE;
        return c;
    endfunction

    task automatic send_cmd(input pdo_cmd_t c, input int n_exp, input pdo_result_t exp_r);
        while (!quiet && $urandom_range(0, 99) < 8)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.command       <= c.command;
        req_ch.frame_id      <= c.frame_id;
        req_ch.frame_payload <= c.frame_payload;
        req_ch.axis          <= c.axis;
        req_ch.target_pulses <= c.target_pulses;
        predict_pdo(c, n_exp == EXP_PREDICTED);
        if (n_exp == EXP_ONE)
        begin
            exp_r.last = 1'b1;
            pending_results.push_back(exp_r);
        end
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic write_deadband(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DEADBAND_ADDR;
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        deadband = value;
    endtask

    // hold until every expected transaction is in, then let the engine finish
    task automatic settle();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
        rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 8);

    always @(posedge clk)
    begin
        pdo_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report($sformatf("unexpected result kind %0d id %h",
                                 rsp_ch.result_kind, rsp_ch.tx_id));
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", rsp_ch.result_kind, want.kind);
                check_field("tx_id", rsp_ch.tx_id, want.tx_id);
                check_field("tx_length", rsp_ch.tx_length, want.tx_length);
                check_field("tx_payload", rsp_ch.tx_payload, want.tx_payload);
                check_field("last", rsp_ch.last, want.last);
                check_field("report_axis", rsp_ch.report_axis, want.axis);
                check_field("report_position", rsp_ch.report_position, want.position);
                check_field("report_velocity", rsp_ch.report_velocity, want.velocity);
                check_field("report_effort", rsp_ch.report_effort, want.effort);
            end
        end
    end

    initial
    begin
        pdo_result_t none_r;
        logic [15:0] phase_band [5];
        none_r = '{default: '0};

        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        req_ch.valid         = 1'b0;
        req_ch.command       = CMD_SYNC;
        req_ch.frame_id      = '0;
        req_ch.frame_payload = '0;
        req_ch.axis          = '0;
        req_ch.target_pulses = '0;
        rsp_ch.ready         = 1'b0;
        quiet                = 1'b0;
        mismatches           = 0;
        cycle_count          = 0;
        deadband             = DEADBAND_RESET;
        foreach (axis_on[i])
        begin
            axis_on[i]  = 1'b0;
            axis_pos[i] = '0;
        end

        // directed part runs at the reset deadband of 50
        add_row(CMD_SYNC, 11'h7FF, '1, 3'd7, 32'hFFFFFFFF, EXP_ONE,
                tx_frame(ID_SYNC, LEN_NONE, '0, '0));
        add_row(CMD_DISABLE, 11'h181, '0, 3'd0, 32'd0, EXP_NONE, none_r);
        add_row(CMD_TARGET, 11'h000, '0, 3'd0, 32'd50, EXP_NONE, none_r);
        add_row(CMD_TARGET, 11'h000, '0, 3'd0, 32'd51, EXP_PREDICTED, none_r);
        add_row(CMD_TARGET, 11'h000, '0, 3'd0, 32'h80000000, EXP_ONE,
                tx_frame(ID_TX_CMD, LEN_FULL, 32'h80000000, CW_MOVE));
        add_row(CMD_TARGET, 11'h000, '0, 3'd7, 32'd1000, EXP_NONE, none_r);
        add_row(CMD_FEEDBACK, ID_RX_POS, 64'hFFFFFFFF_7FFFFFFF, 3'd0, 32'd0, EXP_ONE,
                posvel_report(3'd0, 32'h7FFFFFFF, 32'hFFFFFFFF));
        add_row(CMD_TARGET, 11'h000, '0, 3'd0, 32'h80000000, EXP_PREDICTED, none_r);
        add_row(CMD_TARGET, 11'h000, '0, 3'd0, 32'h7FFFFFCD, EXP_NONE, none_r);
        add_row(CMD_FEEDBACK, ID_RX_POS + 11'd6, 64'h80000000_80000000, 3'd0, 32'd0,
                EXP_ONE, posvel_report(3'd6, 32'h80000000, 32'h80000000));
        add_row(CMD_FEEDBACK, ID_RX_POS + 11'(AXES), '1, 3'd0, 32'd0, EXP_NONE, none_r);
        add_row(CMD_FEEDBACK, ID_RX_POS - 11'd1, '1, 3'd0, 32'd0, EXP_NONE, none_r);
        add_row(CMD_FEEDBACK, ID_RX_EFF, 64'hFFFFFFFF_FFFF8000, 3'd0, 32'd0, EXP_ONE,
                effort_report(3'd0, 16'h8000));
        add_row(CMD_FEEDBACK, ID_RX_EFF + 11'd6, 64'h00000000_00007FFF, 3'd0, 32'd0,
                EXP_ONE, effort_report(3'd6, 16'h7FFF));
        add_row(CMD_FEEDBACK, ID_RX_EFF + 11'(AXES), '1, 3'd0, 32'd0, EXP_NONE, none_r);
        add_row(CMD_FEEDBACK, 11'h7FF, '1, 3'd7, 32'hFFFFFFFF, EXP_NONE, none_r);
        add_row(CMD_FEEDBACK, 11'h000, '0, 3'd0, 32'd0, EXP_NONE, none_r);
        add_row(CMD_TARGET, 11'h000, '0, 3'd6, 32'h7FFFFFFF, EXP_PREDICTED, none_r);
        add_row(CMD_TARGET, 11'h000, '0, 3'd3, -32'sd51, EXP_PREDICTED, none_r);
        add_row(CMD_TARGET, 11'h000, '0, 3'd1, -32'sd50, EXP_NONE, none_r);
        add_row(CMD_TARGET, 11'h000, '0, 3'd2, 32'd0, EXP_NONE, none_r);
        add_row(CMD_DISABLE, 11'h000, '0, 3'd0, 32'd0, EXP_PREDICTED, none_r);
        add_row(CMD_DISABLE, 11'h7FF, '1, 3'd7, 32'hFFFFFFFF, EXP_NONE, none_r);
        add_row(CMD_SYNC, 11'h000, '0, 3'd0, 32'd0, EXP_ONE,
                tx_frame(ID_SYNC, LEN_NONE, '0, '0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, directed_rows[i].n_exp, directed_rows[i].exp_r);
        req_ch.valid <= 1'b0;
        settle();

        phase_band = '{16'd0, 16'hFFFF, 16'($urandom_range(2, 65534)), 16'd1, 16'd50};
        foreach (phase_band[p])
        begin
            write_deadband(phase_band[p]);
            quiet = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // drop the stream until the engine has caught up
                if (i == PHASE_ITEMS / 2)
                begin
                    req_ch.valid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
                send_cmd(random_cmd(), EXP_PREDICTED, none_r);
            end
            req_ch.valid <= 1'b0;
            quiet = 1'b0;
            settle();
        end

        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/mapdo_pkg.sv
hdl/mapdo_if.sv
hdl/multi_axis_pdo_command_feedback.sv
verif/tb_top.sv
